// File: hw/rtl/ppt_pkg.sv
// Package for the piecewise polynomial table: transaction types, defaults, states, helpers.
package ppt_pkg;

  // Default sizes of the table.
  localparam int PPT_ENTRIES    = 16;
  localparam int PPT_IDS        = 4;
  localparam int PPT_MAX_DEGREE = 4;
  localparam int PPT_FRAC_BITS  = 16;

  // Function codes.
  localparam logic FUNC_WRITE = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // Request transaction.
  typedef struct packed {
    logic               func;
    logic [3:0]         entry_index;
    logic [3:0]         word_select;
    logic signed [31:0] write_value;
    logic [2:0]         id_count;
    logic [7:0]         query_id_0;
    logic [7:0]         query_id_1;
    logic [7:0]         query_id_2;
    logic [7:0]         query_id_3;
    logic               check_domain;
    logic signed [31:0] query_point;
  } ppt_req_t;

  // Response transaction.
  typedef struct packed {
    logic               found;
    logic [3:0]         match_index;
    logic               defined;
    logic signed [31:0] value;
  } ppt_rsp_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_WMOD,
    S_QCHK,
    S_EMUL,
    S_EACC,
    S_DONE
  } ppt_state_t;

  // Saturate a 64-bit signed value to 32 bits.
  function automatic logic signed [31:0] sat_w64(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v[63:31] == {33{1'b0}} || v[63:31] == {33{1'b1}}) begin
      r = v[31:0];
    end else if (v[63]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

  // Saturate a 33-bit signed sum to 32 bits.
  function automatic logic signed [31:0] sat_w33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] == v[31]) begin
      r = v[31:0];
    end else if (v[32]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/ppt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ppt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/piecewise_polynomial_table_eval_unit.sv
// Top level: piecewise polynomial table with lookup and Q16.16 evaluation.
// Write: RAM read, merge and write back, then output.
// Query: a RAM read and a compare for each entry walked, then a multiply and an
//   accumulate state for each degree step of the shared multiply-accumulate, then
//   output. One transaction is in work at a time.
// Reset clears the per-entry valid bits at once; an entry not yet written reads as zero.
module piecewise_polynomial_table_eval_unit
  import ppt_pkg::*;
#(
  parameter int ENTRIES    = PPT_ENTRIES,
  parameter int IDS        = PPT_IDS,
  parameter int MAX_DEGREE = PPT_MAX_DEGREE,
  parameter int FRAC_BITS  = PPT_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  ppt_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  output ppt_rsp_t rsp
);

  localparam int AW    = $clog2(ENTRIES);
  localparam int CW    = $clog2(IDS + 1);
  localparam int DW    = $clog2(MAX_DEGREE + 1);
  localparam int NCOEF = MAX_DEGREE + 1;
  localparam int OL    = 8 * IDS + CW;
  localparam int OH    = OL + 32;
  localparam int OD    = OH + 32;
  localparam int HW    = OD + DW;
  localparam int RW    = 32 * NCOEF;

  ppt_state_t state, state_next;
  ppt_req_t   rq;
  ppt_rsp_t   res;

  logic [AW-1:0]    e;
  logic [ENTRIES-1:0] vld;
  logic             vld_q;
  logic             ei_ok;
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic             we;
  logic [HW-1:0]    hdr_rd, hdr_wr, hdr_base;
  logic [RW-1:0]    cof_rd, cof_wr, cof_base;

  // Unpacked view of the current entry.
  logic [7:0]         b_ids [IDS];
  logic [CW-1:0]      b_cnt;
  logic signed [31:0] b_dlo, b_dhi;
  logic [DW-1:0]      b_deg;
  logic signed [31:0] b_cof [NCOEF];
  logic [7:0]         want [IDS];

  logic idok, in_dom, stop, hit;

  // Evaluation datapath.
  logic signed [31:0] cf_q [NCOEF];
  logic [DW-1:0]      deg_q, d;
  logic signed [31:0] acc, xn, tprod, acc_sum;
  logic signed [63:0] p1, p2;

  assign req_stall = (state != S_IDLE);
  assign ei_ok     = int'(rq.entry_index) < ENTRIES;
  assign raddr     = (rq.func == FUNC_WRITE) ? AW'(rq.entry_index) : e;
  assign waddr     = AW'(rq.entry_index);

  ppt_ram #(.WIDTH(HW), .DEPTH(ENTRIES)) u_hdr_ram (
    .clk, .we, .waddr, .wdata(hdr_wr), .raddr, .rdata(hdr_rd)
  );

  ppt_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_cof_ram (
    .clk, .we, .waddr, .wdata(cof_wr), .raddr, .rdata(cof_rd)
  );

  // Entry fields, zero when the entry was never written.
  assign hdr_base = vld_q ? hdr_rd : '0;
  assign cof_base = vld_q ? cof_rd : '0;

  always_comb begin
    for (int k = 0; k < IDS; k++) begin
      b_ids[k] = hdr_base[8*k +: 8];
    end
    b_cnt = hdr_base[8*IDS +: CW];
    b_dlo = hdr_base[OL +: 32];
    b_dhi = hdr_base[OH +: 32];
    b_deg = hdr_base[OD +: DW];
    for (int c = 0; c < NCOEF; c++) begin
      b_cof[c] = cof_base[32*c +: 32];
    end
  end

  // Query identifiers; those past the fourth compare as zero.
  always_comb begin
    for (int k = 0; k < IDS; k++) begin
      case (k)
        0:       want[k] = rq.query_id_0;
        1:       want[k] = rq.query_id_1;
        2:       want[k] = rq.query_id_2;
        3:       want[k] = rq.query_id_3;
        default: want[k] = 8'd0;
      endcase
    end
  end

  // Entry compare for the walk.
  always_comb begin
    idok = (rq.id_count != '0) && (int'(rq.id_count) <= int'(b_cnt));
    for (int k = 0; k < IDS; k++) begin
      if (k < int'(rq.id_count) && b_ids[k] != want[k]) begin
        idok = 1'b0;
      end
    end
    in_dom = !((rq.query_point < b_dlo) || (b_dhi < rq.query_point));
    stop   = (b_dlo == 32'sd0) && (b_dhi == 32'sd0);
    hit    = idok && (!rq.check_domain || in_dom);
  end

  // Merge of one written word into the entry.
  always_comb begin
    logic signed [31:0] wv;
    int                 ws;
    wv     = rq.write_value;
    ws     = int'(rq.word_select);
    hdr_wr = hdr_base;
    cof_wr = cof_base;
    for (int k = 0; k < IDS; k++) begin
      if (ws == k) begin
        hdr_wr[8*k +: 8] = wv[7:0];
      end
    end
    if (ws == IDS) begin
      if (wv < 0) begin
        hdr_wr[8*IDS +: CW] = '0;
      end else if (wv > IDS) begin
        hdr_wr[8*IDS +: CW] = CW'(IDS);
      end else begin
        hdr_wr[8*IDS +: CW] = wv[CW-1:0];
      end
    end
    if (ws == IDS + 1) begin
      hdr_wr[OL +: 32] = wv;
    end
    if (ws == IDS + 2) begin
      hdr_wr[OH +: 32] = wv;
    end
    if (ws == IDS + 3) begin
      if (wv < 0) begin
        hdr_wr[OD +: DW] = '0;
      end else if (wv > MAX_DEGREE) begin
        hdr_wr[OD +: DW] = DW'(MAX_DEGREE);
      end else begin
        hdr_wr[OD +: DW] = wv[DW-1:0];
      end
    end
    for (int c = 0; c < NCOEF; c++) begin
      if (ws == IDS + 4 + c) begin
        cof_wr[32*c +: 32] = wv;
      end
    end
  end

  // Multiply-accumulate step results.
  assign tprod   = sat_w64(p1 >>> FRAC_BITS);
  assign acc_sum = sat_w33({acc[31], acc} + {tprod[31], tprod});

  // Next state and write enable.
  always_comb begin
    state_next = state;
    we         = 1'b0;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_RD;
      end
      S_RD: begin
        if (rq.func == FUNC_WRITE) begin
          state_next = ei_ok ? S_WMOD : S_DONE;
        end else begin
          state_next = S_QCHK;
        end
      end
      S_WMOD: begin
        we         = 1'b1;
        state_next = S_DONE;
      end
      S_QCHK: begin
        if (stop) begin
          state_next = S_DONE;
        end else if (hit) begin
          state_next = (in_dom && b_deg != '0) ? S_EMUL : S_DONE;
        end else if (int'(e) == ENTRIES - 1) begin
          state_next = S_DONE;
        end else begin
          state_next = S_RD;
        end
      end
      S_EMUL: state_next = S_EACC;
      S_EACC: state_next = (d == deg_q) ? S_DONE : S_EMUL;
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register, valid bits and response handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vld       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (we) vld[waddr] <= 1'b1;
      if (rsp_valid && !rsp_stall) rsp_valid <= 1'b0;
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) rsp_valid <= 1'b1;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          rq  <= req;
          res <= '0;
          e   <= '0;
        end
      end
      S_RD: begin
        vld_q <= (rq.func == FUNC_QUERY || ei_ok) ? vld[raddr] : 1'b0;
      end
      S_QCHK: begin
        if (!stop && hit) begin
          res.found       <= 1'b1;
          res.match_index <= 4'(e);
          if (in_dom) begin
            res.defined <= 1'b1;
            res.value   <= b_cof[0];
          end
          for (int c = 0; c < NCOEF; c++) begin
            cf_q[c] <= b_cof[c];
          end
          deg_q <= b_deg;
          acc   <= b_cof[0];
          xn    <= rq.query_point;
          d     <= DW'(1);
        end else begin
          e <= e + 1'b1;
        end
      end
      S_EMUL: begin
        p1 <= cf_q[d] * xn;
        p2 <= xn * rq.query_point;
      end
      S_EACC: begin
        acc       <= acc_sum;
        xn        <= sat_w64(p2 >>> FRAC_BITS);
        d         <= d + 1'b1;
        res.value <= acc_sum;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) rsp <= res;
      end
      default: ;
    endcase
  end

endmodule

// File: hw/rtl/ppt_checker.sv
// Port-level checker for the polynomial table unit, bound to the top level.
module ppt_checker
  import ppt_pkg::*;
(
  input logic     clk,
  input logic     rst,
  input logic     req_valid,
  input logic     req_stall,
  input logic     rsp_valid,
  input logic     rsp_stall,
  input ppt_rsp_t rsp
);

  // One transaction in work: stall follows an accepted request.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall)
    else $error("request accepted while a transaction is in work");

  // A stalled response holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled response changed");

  // No match reports all zero.
  a_miss: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp.found) |->
      (rsp.match_index == 4'd0 && !rsp.defined && rsp.value == 32'sd0))
    else $error("miss response not all zero");

  // A defined value needs a match.
  a_def: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.defined) |-> rsp.found)
    else $error("defined without found");

  // Nothing is reported straight out of reset.
  a_rst: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind piecewise_polynomial_table_eval_unit ppt_checker u_ppt_checker (.*);

// File: dv/testbench.sv
// Testbench for the piecewise polynomial table: directed and random writes and queries checked against a predictor.
module testbench;
  import ppt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     req_valid = 1'b0;
  logic     req_stall;
  ppt_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 1'b0;
  ppt_rsp_t rsp;

  piecewise_polynomial_table_eval_unit i_dut (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  localparam int NCOEF     = PPT_MAX_DEGREE + 1;
  localparam int SEL_COUNT = PPT_IDS;
  localparam int SEL_DLOW  = PPT_IDS + 1;
  localparam int SEL_DHIGH = PPT_IDS + 2;
  localparam int SEL_DEG   = PPT_IDS + 3;
  localparam int SEL_COEF  = PPT_IDS + 4;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the table
  logic [7:0]         tbl_ids    [PPT_ENTRIES][PPT_IDS];
  logic [2:0]         tbl_count  [PPT_ENTRIES];
  logic signed [31:0] tbl_lo     [PPT_ENTRIES];
  logic signed [31:0] tbl_hi     [PPT_ENTRIES];
  logic [2:0]         tbl_deg    [PPT_ENTRIES];
  logic signed [31:0] tbl_coef   [PPT_ENTRIES][NCOEF];

  ppt_req_t pending_reqs[$];
  ppt_rsp_t expected_rsps[$];
  int  errors = 0;
  bit  quiet_tail = 0;
  bit  long_hold = 0;

  function automatic logic signed [31:0] clamp64(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // Truncating Q16.16 product (arithmetic shift floors)
  function automatic logic signed [31:0] q_mul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    return clamp64(p >>> PPT_FRAC_BITS);
  endfunction

  function automatic logic [2:0] sat_small(logic signed [31:0] v, int lim);
    if (v < 0) return 3'd0;
    if (v > lim) return 3'(lim);
    return v[2:0];
  endfunction

  // Apply one transaction to the shadow table and return its response
  function automatic ppt_rsp_t table_step(ppt_req_t r);
    ppt_rsp_t o;
    logic [7:0] qid[4];
    logic signed [31:0] x, acc, xn, t;
    bit ok;
    int m;
    o = '0;
    x = r.query_point;
    qid = '{r.query_id_0, r.query_id_1, r.query_id_2, r.query_id_3};
    if (r.func == FUNC_WRITE) begin
      if (r.word_select < SEL_COUNT)
        tbl_ids[r.entry_index][r.word_select] = r.write_value[7:0];
      else if (r.word_select == SEL_COUNT)
        tbl_count[r.entry_index] = sat_small(r.write_value, PPT_IDS);
      else if (r.word_select == SEL_DLOW) tbl_lo[r.entry_index] = r.write_value;
      else if (r.word_select == SEL_DHIGH) tbl_hi[r.entry_index] = r.write_value;
      else if (r.word_select == SEL_DEG)
        tbl_deg[r.entry_index] = sat_small(r.write_value, PPT_MAX_DEGREE);
      else if (r.word_select < SEL_COEF + NCOEF)
        tbl_coef[r.entry_index][r.word_select - SEL_COEF] = r.write_value;
      return o;
    end
    m = -1;
    for (int e = 0; e < PPT_ENTRIES; e++) begin
      if (tbl_lo[e] == 0 && tbl_hi[e] == 0) break;
      ok = r.id_count != 0 && r.id_count <= tbl_count[e];
      for (int k = 0; k < PPT_IDS; k++)
        if (ok && k < r.id_count && tbl_ids[e][k] != qid[k]) ok = 0;
      if (ok && r.check_domain && (x < tbl_lo[e] || tbl_hi[e] < x)) ok = 0;
      if (ok) begin
        m = e;
        break;
      end
    end
    if (m < 0) return o;
    o.found = 1'b1;
    o.match_index = 4'(m);
    if (!(x < tbl_lo[m] || tbl_hi[m] < x)) begin
      acc = tbl_coef[m][0];
      xn = x;
      for (int d = 1; d <= tbl_deg[m]; d++) begin
        t = q_mul(tbl_coef[m][d], xn);
        acc = clamp64(64'(acc) + 64'(t));
        xn = q_mul(xn, x);
      end
      o.defined = 1'b1;
      o.value = acc;
    end
    return o;
  endfunction

  // Driver: idle bursts, payload held while stalled
  int gap_left = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_rsps.push_back(table_step(req));
        void'(pending_reqs.pop_front());
      end
      if (req_valid && req_stall) begin
        // hold
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        gap_left <= $urandom_range(1, 19) - 1;
        req_valid <= 1'b0;
      end else if ((req_valid && !req_stall ? pending_reqs.size() > 0
                                            : pending_reqs.size() > 0)) begin
        req_valid <= 1'b1;
        req <= pending_reqs[0];
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stall
  int stall_left = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          $error("response with nothing expected");
          errors++;
        end else begin
          ppt_rsp_t want;
          want = expected_rsps.pop_front();
          if (rsp.found !== want.found) begin
            $error("found: expected %0d actual %0d", want.found, rsp.found); errors++;
          end
          if (rsp.match_index !== want.match_index) begin
            $error("match_index: expected %0d actual %0d", want.match_index,
                   rsp.match_index); errors++;
          end
          if (rsp.defined !== want.defined) begin
            $error("defined: expected %0d actual %0d", want.defined, rsp.defined); errors++;
          end
          if (rsp.value !== want.value) begin
            $error("value: expected %0d actual %0d", want.value, rsp.value); errors++;
          end
        end
      end
      if (long_hold && hold_cnt < 300) begin
        hold_cnt <= hold_cnt + 1;
        rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        rsp_stall <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 19) - 1;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  function automatic ppt_req_t wr(int e, int s, logic signed [31:0] v);
    ppt_req_t r;
    r = '0;
    r.func = FUNC_WRITE;
    r.entry_index = 4'(e);
    r.word_select = 4'(s);
    r.write_value = v;
    // junk in the unused query fields
    r.query_point = $urandom;
    r.query_id_0 = 8'($urandom);
    return r;
  endfunction

  function automatic ppt_req_t qry(int n, logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                   logic [7:0] d, bit chk, logic signed [31:0] x);
    ppt_req_t r;
    r = '0;
    r.func = FUNC_QUERY;
    r.entry_index = 4'($urandom);
    r.word_select = 4'($urandom);
    r.write_value = $urandom;
    r.id_count = 3'(n);
    r.query_id_0 = a; r.query_id_1 = b; r.query_id_2 = c; r.query_id_3 = d;
    r.check_domain = chk;
    r.query_point = x;
    return r;
  endfunction

  function automatic logic signed [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return $signed(32'($urandom_range(0, 32'h3ffff))) - 32'sh2_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    logic [7:0] ids[4];
    int e, n;
    foreach (tbl_count[i]) begin
      tbl_count[i] = 0; tbl_lo[i] = 0; tbl_hi[i] = 0; tbl_deg[i] = 0;
    end
    foreach (tbl_ids[i, k]) tbl_ids[i][k] = 0;
    foreach (tbl_coef[i, k]) tbl_coef[i][k] = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Directed: empty table, then entry 0 with full ids and max degree
    pending_reqs.push_back(qry(1, 0, 0, 0, 0, 0, 0));
    pending_reqs.push_back(wr(0, 0, 32'h1ab));
    pending_reqs.push_back(wr(0, 1, 32'hff));
    pending_reqs.push_back(wr(0, 2, 0));
    pending_reqs.push_back(wr(0, 3, 32'h55));
    pending_reqs.push_back(wr(0, SEL_COUNT, 32'sd99));
    pending_reqs.push_back(wr(0, SEL_DLOW, -32'sh3_0000));
    pending_reqs.push_back(wr(0, SEL_DHIGH, 32'sh3_0000));
    pending_reqs.push_back(wr(0, SEL_DEG, -32'sd5));
    pending_reqs.push_back(wr(0, SEL_DEG, 32'sd77));
    for (int k = 0; k < NCOEF; k++) pending_reqs.push_back(wr(0, SEL_COEF + k, 32'sh7fff_ffff));
    pending_reqs.push_back(wr(15, 13, 32'h1234));
    pending_reqs.push_back(wr(1, 15, 32'h1234));
    pending_reqs.push_back(qry(4, 8'hab, 8'hff, 0, 0, 0, 32'sh2_0000));
    pending_reqs.push_back(qry(4, 8'hab, 8'hff, 0, 8'h55, 1, 32'sh2_0000));
    pending_reqs.push_back(qry(4, 8'hab, 8'hff, 0, 8'h55, 0, 32'sh8000_0000));
    pending_reqs.push_back(qry(4, 8'hab, 8'hff, 0, 8'h55, 1, 32'sh7fff_ffff));
    pending_reqs.push_back(qry(0, 8'hab, 8'hff, 0, 8'h55, 0, 0));
    pending_reqs.push_back(qry(7, 8'hab, 8'hff, 0, 8'h55, 0, 0));
    pending_reqs.push_back(qry(2, 8'hab, 8'hff, 8'hff, 8'hff, 1, -32'sh3_0000));
    wait_drained();
    // Receiver holds off while the sender keeps offering
    long_hold = 1;
    for (int i = 0; i < 20; i++)
      pending_reqs.push_back(qry($urandom_range(0, 4), 8'hab, 8'hff, 0, 8'h55,
                                 $urandom_range(0, 1), $urandom));
    wait_drained();
    // Random: mostly populated table with matching queries
    for (int i = 0; i < 1000; i++) begin
      if (i == 900) begin
        wait_drained();
        quiet_tail = 1;
      end
      e = $urandom_range(0, 15);
      if ($urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 3) == 0) n = $urandom_range(0, 15);
        else n = $urandom_range(0, 12);
        case ($urandom_range(0, 4))
          0: pending_reqs.push_back(wr(e, n, $urandom));
          1: pending_reqs.push_back(wr(e, n, $urandom_range(0, 4) - 1));
          2: pending_reqs.push_back(wr(e, $urandom_range(0, 3), $urandom_range(0, 3)));
          default: pending_reqs.push_back(wr(e, n, rnd_val()));
        endcase
      end else begin
        // Aim ids at an existing entry most of the time
        e = $urandom_range(0, 7);
        for (int k = 0; k < 4; k++)
          ids[k] = ($urandom_range(0, 4) == 0) ? 8'($urandom) : tbl_ids[e][k];
        pending_reqs.push_back(qry($urandom_range(0, 7), ids[0], ids[1], ids[2], ids[3],
                                   $urandom_range(0, 1),
                                   ($urandom_range(0, 2) == 0) ? rnd_val() :
                                   $signed(32'($urandom_range(0, 32'h8_0000))) -
                                   32'sh4_0000));
      end
      // keep predictor state in step with issue order for targeting
      while (pending_reqs.size() >= 4) @(posedge clk);
    end
    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Hard limit
  initial begin
    #20ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/ppt_pkg.sv
hw/rtl/ppt_ram.sv
hw/rtl/piecewise_polynomial_table_eval_unit.sv
hw/rtl/ppt_checker.sv
dv/testbench.sv
